// File: sv/ascii_to_scancode_translator_core_defines.svh
// assertion macros used by the translator rtl
`ifndef ASCII_TO_SCANCODE_TRANSLATOR_CORE_DEFINES_SVH
`define ASCII_TO_SCANCODE_TRANSLATOR_CORE_DEFINES_SVH

// same-cycle implication, checked outside reset
`define A2S_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("a2s assertion failed");

// next-cycle implication, checked outside reset
`define A2S_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("a2s assertion failed");

`endif

// File: sv/a2s_pkg.sv
// types, constants and lookup functions for the ascii to scan code translator
package a2s_pkg;

   // result transfer payload
   typedef struct packed {
      logic       kind;
      logic [7:0] key_code;
      logic       odd_parity;
      logic [3:0] delay_units;
   } result_type;

   localparam logic       KIND_KEY   = 1'b0;
   localparam logic       KIND_DELAY = 1'b1;

   localparam logic [7:0] CARET        = 8'h5E;
   localparam logic [7:0] EXECUTE_CODE = 8'hB2;

   // named key codes reachable through an escape
   localparam logic [7:0] KEY_LEFT    = 8'h34;
   localparam logic [7:0] KEY_RIGHT   = 8'hB4;
   localparam logic [7:0] KEY_UP      = 8'hDF;
   localparam logic [7:0] KEY_DOWN    = 8'h4F;
   localparam logic [7:0] KEY_HOLD    = 8'h36;
   localparam logic [7:0] KEY_ATTN    = 8'hB6;
   localparam logic [7:0] KEY_CMD_A   = 8'h96;
   localparam logic [7:0] KEY_CMD_P   = 8'h91;
   localparam logic [7:0] KEY_CMD_M   = 8'h93;
   localparam logic [7:0] KEY_CMD_S   = 8'h95;
   localparam logic [7:0] KEY_NONE    = 8'h00;

   // lower half of the scan code rom; upper half is all zero
   localparam logic [7:0] SCAN_ROM [128] = '{
      8'h00,8'hDF,8'h91,8'h00,8'h00,8'h00,8'h00,8'h93,
      8'h34,8'h00,8'hB2,8'h00,8'h36,8'hB2,8'h00,8'h34,
      8'hB4,8'h00,8'h96,8'h00,8'h95,8'h00,8'h00,8'h00,
      8'h00,8'h00,8'h4F,8'hB6,8'h00,8'h00,8'h00,8'h00,
      8'h39,8'h00,8'h4C,8'h30,8'h4B,8'h00,8'h4A,8'hFA,
      8'h3A,8'hBA,8'h9D,8'h99,8'hF9,8'h9B,8'h89,8'h00,
      8'h8F,8'h4D,8'h0F,8'hCF,8'hAF,8'h2F,8'hEF,8'h6F,
      8'h7F,8'hFF,8'h88,8'hF8,8'hCE,8'h32,8'h6E,8'h0C,
      8'h70,8'h0B,8'hE9,8'hA9,8'hAB,8'hAD,8'h2B,8'hEB,
      8'h6B,8'hFD,8'h7B,8'hFB,8'h8B,8'h79,8'h69,8'h8D,
      8'h3D,8'h0D,8'h2D,8'hCB,8'hED,8'h7D,8'h29,8'hCD,
      8'hC9,8'h6D,8'h09,8'h00,8'h00,8'h00,8'h00,8'h00,
      8'h00,8'h0B,8'hE9,8'hA9,8'hAB,8'hAD,8'h2B,8'hEB,
      8'h6B,8'hFD,8'h7B,8'hFB,8'h8B,8'h79,8'h69,8'h8D,
      8'h3D,8'h0D,8'h2D,8'hCB,8'hED,8'h7D,8'h29,8'hCD,
      8'hC9,8'h6D,8'h09,8'h00,8'h00,8'h00,8'h96,8'h34
   };

   function automatic logic [7:0] scan_lookup(input logic [7:0] ch);
      scan_lookup = ch[7] ? 8'h00 : SCAN_ROM[ch[6:0]];
   endfunction

   // key result with odd parity over the code
   function automatic result_type key_result(input logic [7:0] code);
      result_type r;
      r.kind        = KIND_KEY;
      r.key_code    = code;
      r.odd_parity  = ^code;
      r.delay_units = 4'd0;
      key_result = r;
   endfunction

endpackage

// File: sv/a2s_engine.sv
// escape state and byte translation, one accepted byte per cycle
module a2s_engine import a2s_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       accept,
   input  logic [7:0] rx_byte,
   output logic       push,
   output result_type result
);

   logic       escape_ff, escape_in;
   logic [1:0] held_ff, held_in;
   logic [7:0] first_ff, first_in;
   logic [7:0] second_ff, second_in;
   logic       newline_ff, newline_in;

   logic [7:0] code;
   logic       is_caret;

   assign code     = scan_lookup(rx_byte);
   assign is_caret = (rx_byte == CARET);

   // next state and result for the byte at the input
   always_comb begin
      escape_in  = escape_ff;
      held_in    = held_ff;
      first_in   = first_ff;
      second_in  = second_ff;
      newline_in = newline_ff;
      push       = 1'b0;
      result     = key_result(KEY_NONE);
      if (escape_ff) begin
         // hold the first two bytes, closing caret included
         if (held_ff == 2'd0) begin
            first_in = rx_byte;
            held_in  = 2'd1;
         end else if (held_ff == 2'd1) begin
            second_in = rx_byte;
            held_in   = 2'd2;
         end
         if (is_caret) begin
            escape_in = 1'b0;
            held_in   = 2'd0;
            push      = 1'b1;
            case (first_in)
               "L": if (second_in == "E") result = key_result(KEY_LEFT);
                    else push = 1'b0;
               "R": if (second_in == "I") result = key_result(KEY_RIGHT);
                    else push = 1'b0;
               "U": if (second_in == "P") result = key_result(KEY_UP);
                    else push = 1'b0;
               "H": if (second_in == "O") result = key_result(KEY_HOLD);
                    else push = 1'b0;
               "A": if (second_in == "T") result = key_result(KEY_ATTN);
                    else push = 1'b0;
               "D": begin
                  if (second_in == "O") begin
                     result = key_result(KEY_DOWN);
                  end else if (second_in inside {["1":"9"]}) begin
                     result.kind        = KIND_DELAY;
                     result.key_code    = 8'h00;
                     result.odd_parity  = 1'b0;
                     result.delay_units = second_in[3:0];
                  end else begin
                     push = 1'b0;
                  end
               end
               "E": begin
                  case (second_in)
                     "X": result = key_result(EXECUTE_CODE);
                     "0": newline_in = 1'b0;
                     "1": newline_in = 1'b1;
                     default: push = 1'b0;
                  endcase
               end
               "C": begin
                  case (second_in)
                     "A": result = key_result(KEY_CMD_A);
                     "P": result = key_result(KEY_CMD_P);
                     "M": result = key_result(KEY_CMD_M);
                     "S": result = key_result(KEY_CMD_S);
                     default: push = 1'b0;
                  endcase
               end
               default: push = 1'b0;
            endcase
         end
      end else begin
         // normal mode: rom lookup, execute gated by translation flag, caret opens an escape
         if (code == EXECUTE_CODE && !newline_ff) begin
            push = 1'b0;
         end else if (code == 8'h00) begin
            if (is_caret) begin
               escape_in = 1'b1;
               held_in   = 2'd0;
            end
         end else begin
            push   = 1'b1;
            result = key_result(code);
         end
      end
      push = push & accept;
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         escape_ff  <= 1'b0;
         held_ff    <= 2'd0;
         newline_ff <= 1'b1;
      end else if (accept) begin
         escape_ff  <= escape_in;
         held_ff    <= held_in;
         newline_ff <= newline_in;
      end
   end

   // held escape characters, undefined until written
   always_ff @(posedge clock) begin
      if (accept) begin
         first_ff  <= first_in;
         second_ff <= second_in;
      end
   end

endmodule

// File: sv/a2s_skid.sv
// two-entry result register with skid stage
`include "ascii_to_scancode_translator_core_defines.svh"
module a2s_skid import a2s_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       push,
   input  result_type push_data,
   output logic       full,
   output logic       out_valid,
   input  logic       out_stall,
   output result_type out_data
);

   logic       main_valid_ff, skid_valid_ff;
   result_type main_ff, skid_ff;
   logic       pop;

   assign pop       = main_valid_ff & ~out_stall;
   assign full      = skid_valid_ff;
   assign out_valid = main_valid_ff;
   assign out_data  = main_ff;

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (skid_valid_ff) begin
         if (pop) skid_valid_ff <= 1'b0;
      end else if (main_valid_ff && !pop) begin
         if (push) skid_valid_ff <= 1'b1;
      end else begin
         main_valid_ff <= push;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      if (skid_valid_ff) begin
         if (pop) main_ff <= skid_ff;
      end else if (main_valid_ff && !pop) begin
         if (push) skid_ff <= push_data;
      end else if (push) begin
         main_ff <= push_data;
      end
   end

   `A2S_ASSERT_NOW(skid_needs_main, skid_valid_ff, main_valid_ff)
   `A2S_ASSERT_NOW(no_push_when_full, push, !skid_valid_ff)
   `A2S_ASSERT_NEXT(stalled_result_kept, main_valid_ff && out_stall, main_valid_ff)
   `A2S_ASSERT_NEXT(skid_drains_first, skid_valid_ff && pop, main_ff == $past(skid_ff))

endmodule

// File: sv/ascii_to_scancode_translator_core.sv
// top level of the ascii to scan code translator
//
//   channel   direction  payload                                         flow
//   req_      in         rx_byte                                         valid / stall
//   rsp_      out        kind, key_code, odd_parity, delay_units         valid / stall
//
// one byte is accepted per cycle unless stalled; its result (if any) is registered
// the escape decode and rom lookup sit between the byte input and the result register
// a skid entry behind the result register keeps req_ open one extra transfer under stall
// req_stall rises only while both result entries hold data
// synchronous reset clears escape state and turns newline translation on
module ascii_to_scancode_translator_core import a2s_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_rx_byte,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic       rsp_kind,
   output logic [7:0] rsp_key_code,
   output logic       rsp_odd_parity,
   output logic [3:0] rsp_delay_units
);

   logic       accept;
   logic       push;
   result_type result;
   result_type out_data;

   assign accept = req_valid & ~req_stall;

   // translation
   a2s_engine u_engine (
      .clock   (clock),
      .reset   (reset),
      .accept  (accept),
      .rx_byte (req_rx_byte),
      .push    (push),
      .result  (result)
   );

   // result buffering
   a2s_skid u_skid (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (result),
      .full      (req_stall),
      .out_valid (rsp_valid),
      .out_stall (rsp_stall),
      .out_data  (out_data)
   );

   assign rsp_kind        = out_data.kind;
   assign rsp_key_code    = out_data.key_code;
   assign rsp_odd_parity  = out_data.odd_parity;
   assign rsp_delay_units = out_data.delay_units;

endmodule

// File: tb/tb_ascii_to_scancode_translator_core.sv
// testbench for the ascii to scan code translator core
`timescale 1ns / 1ps

module tb_ascii_to_scancode_translator_core;
   import a2s_pkg::*;

   localparam int WATCHDOG_LIMIT = 1000;
   localparam int HOLD_CYCLES    = 150;
   localparam int DRAIN_CYCLES   = 4;
   localparam int IDLE_PCT       = 18;

   localparam logic [7:0] LF_BYTE = 8'h0A;
   localparam logic [7:0] CR_BYTE = 8'h0D;

   // lower half of the byte to scan code table; bytes with bit 7 set map to nothing
   localparam logic [7:0] SCAN_TABLE [128] = '{
      8'h00,8'hDF,8'h91,8'h00,8'h00,8'h00,8'h00,8'h93,
      8'h34,8'h00,8'hB2,8'h00,8'h36,8'hB2,8'h00,8'h34,
      8'hB4,8'h00,8'h96,8'h00,8'h95,8'h00,8'h00,8'h00,
      8'h00,8'h00,8'h4F,8'hB6,8'h00,8'h00,8'h00,8'h00,
      8'h39,8'h00,8'h4C,8'h30,8'h4B,8'h00,8'h4A,8'hFA,
      8'h3A,8'hBA,8'h9D,8'h99,8'hF9,8'h9B,8'h89,8'h00,
      8'h8F,8'h4D,8'h0F,8'hCF,8'hAF,8'h2F,8'hEF,8'h6F,
      8'h7F,8'hFF,8'h88,8'hF8,8'hCE,8'h32,8'h6E,8'h0C,
      8'h70,8'h0B,8'hE9,8'hA9,8'hAB,8'hAD,8'h2B,8'hEB,
      8'h6B,8'hFD,8'h7B,8'hFB,8'h8B,8'h79,8'h69,8'h8D,
      8'h3D,8'h0D,8'h2D,8'hCB,8'hED,8'h7D,8'h29,8'hCD,
      8'hC9,8'h6D,8'h09,8'h00,8'h00,8'h00,8'h00,8'h00,
      8'h00,8'h0B,8'hE9,8'hA9,8'hAB,8'hAD,8'h2B,8'hEB,
      8'h6B,8'hFD,8'h7B,8'hFB,8'h8B,8'h79,8'h69,8'h8D,
      8'h3D,8'h0D,8'h2D,8'hCB,8'hED,8'h7D,8'h29,8'hCD,
      8'hC9,8'h6D,8'h09,8'h00,8'h00,8'h00,8'h96,8'h34
   };

   // escape names that decode to a key
   localparam logic [15:0] NAMED_PAIRS [11] = '{
      "LE", "RI", "UP", "DO", "HO", "EX", "AT", "CA", "CP", "CM", "CS"
   };

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_stall;
   logic [7:0] req_rx_byte = 8'h00;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   logic       rsp_kind;
   logic [7:0] rsp_key_code;
   logic       rsp_odd_parity;
   logic [3:0] rsp_delay_units;

   // translator state as the predictor sees it
   logic       esc_open = 1'b0;
   logic [1:0] esc_count = 2'd0;
   logic [7:0] esc_first = 8'h00;
   logic [7:0] esc_second = 8'h00;
   logic       newline_on = 1'b1;
   bit         esc_second_written = 1'b0;

   result_type expected_results[$];
   result_type next_result;
   int         error_count = 0;
   int         sent_bytes = 0;
   int         quiet_cycles = 0;
   int         sender_gap_pct = IDLE_PCT;
   int         sink_stall_pct = IDLE_PCT;
   bit         hold_request = 1'b0;

   ascii_to_scancode_translator_core uut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_rx_byte     (req_rx_byte),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_kind        (rsp_kind),
      .rsp_key_code    (rsp_key_code),
      .rsp_odd_parity  (rsp_odd_parity),
      .rsp_delay_units (rsp_delay_units)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // key result with parity over the code
   function automatic result_type predicted_key(input logic [7:0] code);
      result_type r;
      r.kind        = KIND_KEY;
      r.key_code    = code;
      r.odd_parity  = ^code;
      r.delay_units = 4'd0;
      return r;
   endfunction

   // decode the two held characters when the escape closes
   function automatic void decode_held_pair();
      result_type r;
      case ({esc_first, esc_second})
         "LE": expected_results.push_back(predicted_key(KEY_LEFT));
         "RI": expected_results.push_back(predicted_key(KEY_RIGHT));
         "UP": expected_results.push_back(predicted_key(KEY_UP));
         "DO": expected_results.push_back(predicted_key(KEY_DOWN));
         "HO": expected_results.push_back(predicted_key(KEY_HOLD));
         "EX": expected_results.push_back(predicted_key(EXECUTE_CODE));
         "AT": expected_results.push_back(predicted_key(KEY_ATTN));
         "CA": expected_results.push_back(predicted_key(KEY_CMD_A));
         "CP": expected_results.push_back(predicted_key(KEY_CMD_P));
         "CM": expected_results.push_back(predicted_key(KEY_CMD_M));
         "CS": expected_results.push_back(predicted_key(KEY_CMD_S));
         "E0": begin
            newline_on = 1'b0;
            expected_results.push_back(predicted_key(KEY_NONE));
         end
         "E1": begin
            newline_on = 1'b1;
            expected_results.push_back(predicted_key(KEY_NONE));
         end
         default: begin
            // delay request, one to nine delay units
            if (esc_first == "D" && esc_second >= "1" && esc_second <= "9") begin
               r.kind        = KIND_DELAY;
               r.key_code    = 8'h00;
               r.odd_parity  = 1'b0;
               r.delay_units = 4'(esc_second - "0");
               expected_results.push_back(r);
            end
         end
      endcase
   endfunction

   // advance the predictor by one accepted byte; returns 0 when the byte is ignored
   function automatic bit translate_byte(input logic [7:0] b);
      logic [7:0] code;
      if (esc_open) begin
         if (esc_count == 2'd0) begin
            esc_first = b;
            esc_count = 2'd1;
         end else if (esc_count == 2'd1) begin
            esc_second = b;
            esc_count = 2'd2;
            esc_second_written = 1'b1;
         end
         if (b == CARET) begin
            esc_open  = 1'b0;
            esc_count = 2'd0;
            decode_held_pair();
         end
         return 1'b1;
      end
      code = b[7] ? KEY_NONE : SCAN_TABLE[b[6:0]];
      if (code == EXECUTE_CODE && !newline_on)
         return 1'b0;
      if (code == KEY_NONE) begin
         if (b == CARET) begin
            esc_open  = 1'b1;
            esc_count = 2'd0;
            return 1'b1;
         end
         return 1'b0;
      end
      expected_results.push_back(predicted_key(code));
      return 1'b1;
   endfunction

   // one req_ transfer, with a random gap in front of it
   task automatic send_byte(input logic [7:0] b);
      int gap;
      gap = 0;
      // an empty escape would decode a second slot that was never written
      if (esc_open && esc_count == 2'd0 && b == CARET && !esc_second_written)
         b = "A";
      while ($urandom_range(99) < sender_gap_pct)
         gap++;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_rx_byte <= b;
      do @(posedge clock); while (req_stall);
      void'(translate_byte(b));
      sent_bytes++;
   endtask

   // caret, up to six held characters, closing caret
   task automatic send_escape(input logic [15:0] pair, input int content_len);
      send_byte(CARET);
      if (content_len > 0)
         send_byte(pair[15:8]);
      if (content_len > 1)
         send_byte(pair[7:0]);
      for (int i = 2; i < content_len; i++)
         send_byte(8'($urandom_range(8'h20, 8'h7E)));
      send_byte(CARET);
   endtask

   // sender stops and waits until every result has arrived
   task automatic wait_for_results();
      req_valid <= 1'b0;
      while (expected_results.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   function automatic logic [7:0] noise_byte();
      case ($urandom_range(0, 9))
         0, 1, 2: return 8'($urandom_range(0, 255));
         3, 4, 5: return 8'($urandom_range(8'h20, 8'h7E));
         6:       return 8'($urandom_range(0, 8'h1F));
         7:       return $urandom_range(0, 1) ? LF_BYTE : CR_BYTE;
         default: return 8'($urandom_range(8'h80, 8'hFF));
      endcase
   endfunction

   function automatic logic [15:0] pick_pair();
      case ($urandom_range(0, 9))
         0, 1, 2, 3: return NAMED_PAIRS[$urandom_range(0, 10)];
         4, 5:       return {"D", 8'("0" + $urandom_range(1, 9))};
         6:          return $urandom_range(0, 1) ? "E0" : "E1";
         // delay digits and the near misses around them
         7:          return {"D", 8'($urandom_range(8'h2F, 8'h3A))};
         8:          return {8'($urandom_range(8'h41, 8'h5A)), 8'($urandom_range(8'h30, 8'h5A))};
         default:    return {8'($urandom), 8'($urandom)};
      endcase
   endfunction

   function automatic int pick_content_len();
      case ($urandom_range(0, 9))
         0:       return 0;
         1:       return 1;
         2:       return $urandom_range(3, 6);
         default: return 2;
      endcase
   endfunction

   // mostly escapes, well formed or malformed, the rest plain and stray bytes
   task automatic run_random_traffic(input int target);
      int start;
      start = sent_bytes;
      while (sent_bytes - start < target) begin
         if ($urandom_range(99) < 55)
            send_escape(pick_pair(), pick_content_len());
         else
            repeat ($urandom_range(1, 4)) send_byte(noise_byte());
      end
   endtask

   // plain bytes: execute passes after reset, table extremes, zero entries
   task automatic test_plain_bytes();
      send_byte(CR_BYTE);
      send_byte(8'h00);
      send_byte(8'hFF);
      wait_for_results();
   endtask

   // named key with an extra held char, and the largest delay
   task automatic test_escape_decode();
      send_escape("LE", 3);
      send_escape("D9", 2);
      wait_for_results();
   endtask

   // translation off drops execute bytes but not the execute escape
   task automatic test_newline_toggle();
      send_escape("E0", 2);
      send_byte(LF_BYTE);
      send_escape("EX", 2);
      send_escape("E1", 2);
      wait_for_results();
   endtask

   // empty escape decodes the caret and a stale second slot
   task automatic test_stale_escape();
      send_escape("^^", 0);
      wait_for_results();
   endtask

   task automatic test_random_traffic();
      run_random_traffic(1050);
      wait_for_results();
   endtask

   // receiver holds off while the sender keeps offering keys
   task automatic test_backpressure();
      // a stray caret may have left an escape open; close it so keys come out
      if (esc_open)
         send_byte(CARET);
      sender_gap_pct = 0;
      hold_request   = 1'b1;
      repeat (40) send_byte(8'($urandom_range(8'h61, 8'h7A)));
      sender_gap_pct = IDLE_PCT;
      wait_for_results();
   endtask

   // both sides at full rate
   task automatic test_full_rate();
      sender_gap_pct = 0;
      sink_stall_pct = 0;
      run_random_traffic(250);
      sender_gap_pct = IDLE_PCT;
      sink_stall_pct = IDLE_PCT;
      wait_for_results();
   endtask

   // receiver: random stalls, plus one long hold on request
   initial begin
      forever begin
         @(posedge clock);
         if (hold_request) begin
            hold_request = 1'b0;
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clock);
         end
         rsp_stall <= ($urandom_range(99) < sink_stall_pct);
      end
   end

   // compare each rsp_ transfer against the oldest prediction
   task automatic check_field(input string field, input logic [7:0] want,
                              input logic [7:0] got);
      if (got !== want) begin
         error_count++;
         $display("%0t: rsp_%s mismatch, expected %h, actual %h", $time, field, want, got);
      end
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_results.size() == 0) begin
            error_count++;
            $display("%0t: unexpected transfer, expected none, actual kind %0d code %h delay %0d",
                     $time, rsp_kind, rsp_key_code, rsp_delay_units);
         end else begin
            next_result = expected_results.pop_front();
            check_field("kind", 8'(next_result.kind), 8'(rsp_kind));
            check_field("key_code", next_result.key_code, rsp_key_code);
            check_field("odd_parity", 8'(next_result.odd_parity), 8'(rsp_odd_parity));
            check_field("delay_units", 8'(next_result.delay_units), 8'(rsp_delay_units));
         end
      end
   end

   // watchdog on cycles without any transfer
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         quiet_cycles = 0;
      else
         quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("tb_ascii_to_scancode_translator_core: done, errors");
         $finish;
      end
   end

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      test_plain_bytes();
      test_escape_decode();
      test_newline_toggle();
      test_stale_escape();
      test_random_traffic();
      test_backpressure();
      test_full_rate();
      if (error_count == 0)
         $display("tb_ascii_to_scancode_translator_core: done, clean");
      else
         $display("tb_ascii_to_scancode_translator_core: done, errors");
      $finish;
   end

endmodule

// File: files.f
+incdir+sv
sv/a2s_pkg.sv
sv/a2s_engine.sv
sv/a2s_skid.sv
sv/ascii_to_scancode_translator_core.sv
tb/tb_ascii_to_scancode_translator_core.sv
